/* rtl/adu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package adu_pkg;

  // Number of accumulator slots held in the state memory.
  localparam int unsigned SLOTS = 64;
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int unsigned MEAN_W = 48;
  localparam int unsigned ACC_W  = 65;

  localparam logic [15:0] DECAY_RATE_RST = 16'd655;
  localparam logic [31:0] EPS_ADD_RST    = 32'd4295;

  // Configuration register indexes.
  localparam logic CFG_DECAY_RATE = 1'b0;
  localparam logic CFG_EPS_ADD    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_SQW1,
    S_SQW2,
    S_B0,
    S_B1,
    S_B2,
    S_B3,
    S_BW1,
    S_BW2,
    S_ROOT,
    S_MQ,
    S_MQW1,
    S_MQW2,
    S_DIV,
    S_QSEL,
    S_WB,
    S_OUT
  } state_e;

  function automatic logic [MEAN_W-1:0] clip48(input logic [ACC_W-1:0] v);
    logic [MEAN_W-1:0] r;
    if (v[ACC_W-1:MEAN_W] != '0) begin
      r = '1;
    end else begin
      r = v[MEAN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/adadelta_step_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: slot[5:0], gradient[37:6], zero pad[39:38]
// m_axis    out        tdata: change[31:0]; tuser: saturated
// cfg       in         cfg_idx_i 0 = decay rate, 1 = epsilon; cfg_data_i 32 bits
//
// A word is taken only in the idle state. The block then loads the slot and blends the
// gradient mean, runs the two 32-step square roots side by side, forms |g| * root, runs
// the 33-step divider, saturates, and then blends the change mean, writes the slot back
// and loads the output register once that register is free.
// A new word is taken only after the last result is in the output register; the shared
// 32x32 multiplier and the iterative root and divide units keep the block busy until then.
// Reset clears the per-slot valid bits, so every slot reads as zero until written.
// A stalled output holds a finished result in the output register; the block waits in
// its last state until that register is free and then returns to idle.
module adadelta_step_update (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // slot[5:0], gradient[37:6], pad
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // change[31:0]
  output logic             m_axis_tuser_o,   // saturated
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned AW = adu_pkg::SLOT_AW;
  localparam int unsigned MW = adu_pkg::MEAN_W;
  localparam int unsigned AC = adu_pkg::ACC_W;
  localparam int unsigned SLOTS_CMP_W = 13;

  adu_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] lr_q;
  logic [31:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= adu_pkg::DECAY_RATE_RST;
      eps_q <= adu_pkg::EPS_ADD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        adu_pkg::CFG_DECAY_RATE: lr_q  <= cfg_data_i[15:0];
        adu_pkg::CFG_EPS_ADD:    eps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [AW-1:0] addr_q;
  logic          in_range_q;
  logic          neg_q;
  logic [31:0]   mag_q;
  logic          pass_q;
  logic [MW-1:0] eg_old_q, ed_old_q, eg_new_q, ed_new_q, x_q;
  logic [31:0]   q_q;
  logic          sat_q;
  logic [31:0]   rb_q;

  logic          accept;
  logic [31:0]   g_in;
  logic [SLOTS_CMP_W-1:0] slot_ext;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign g_in     = s_axis_tdata_i[37:6];
  assign slot_ext = SLOTS_CMP_W'(s_axis_tdata_i[5:0]);

  // State memory: {change mean, gradient mean} per slot, with a valid bit per slot.
  logic [2*MW-1:0] rd_data;
  logic [adu_pkg::SLOTS-1:0] vld_q;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;

  assign ram_raddr = AW'(s_axis_tdata_i[5:0]);
  assign ram_we    = (state_q == adu_pkg::S_WB) && in_range_q;

  adu_ram #(
    .DEPTH(adu_pkg::SLOTS),
    .WIDTH(2 * MW),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i({ed_new_q, eg_new_q}),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // Root unit outputs, read by the multiplier select below.
  logic          root_go;
  logic [63:0]   sqa_op, sqb_op;
  logic          sqa_busy, sqb_busy;
  logic [31:0]   sqa_root, sqb_root;

  // Shared multiplier with a registered product and a shifted accumulate.
  logic [31:0]   mul_a, mul_b;
  logic          mul_go, mul_clr, mul_sh;
  logic [63:0]   prod_q;
  logic          add_q, clr_q, sh_q;
  logic [AC-1:0] acc_q;
  logic [AC-1:0] prod_sh;
  logic [16:0]   w0;
  logic [MW-1:0] old_sel;

  assign w0      = 17'h10000 - {1'b0, lr_q};
  assign old_sel = pass_q ? ed_old_q : eg_old_q;
  assign prod_sh = sh_q ? {prod_q[32:0], 32'h0} : AC'(prod_q);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_go  = 1'b0;
    mul_clr = 1'b0;
    mul_sh  = 1'b0;
    case (state_q)
      adu_pkg::S_SQ: begin
        mul_a   = pass_q ? q_q : mag_q;
        mul_b   = pass_q ? q_q : mag_q;
        mul_go  = 1'b1;
        mul_clr = 1'b1;
      end
      adu_pkg::S_B0: begin
        mul_a   = 32'(w0);
        mul_b   = old_sel[31:0];
        mul_go  = 1'b1;
        mul_clr = 1'b1;
      end
      adu_pkg::S_B1: begin
        mul_a  = 32'(w0);
        mul_b  = 32'(old_sel[MW-1:32]);
        mul_go = 1'b1;
        mul_sh = 1'b1;
      end
      adu_pkg::S_B2: begin
        mul_a  = 32'(lr_q);
        mul_b  = x_q[31:0];
        mul_go = 1'b1;
      end
      adu_pkg::S_B3: begin
        mul_a  = 32'(lr_q);
        mul_b  = 32'(x_q[MW-1:32]);
        mul_go = 1'b1;
        mul_sh = 1'b1;
      end
      adu_pkg::S_MQ: begin
        mul_a   = mag_q;
        mul_b   = sqa_root;
        mul_go  = 1'b1;
        mul_clr = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
    end else begin
      add_q <= mul_go;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    clr_q  <= mul_clr;
    sh_q   <= mul_sh;
    if (add_q) begin
      acc_q <= clr_q ? prod_sh : acc_q + prod_sh;
    end
  end

  // Square roots of (mean + eps) << 14, both started together.
  assign root_go = (state_q == adu_pkg::S_BW2) && !pass_q;
  assign sqa_op  = {1'b0, ({1'b0, ed_old_q} + 49'(eps_q)), 14'h0};
  assign sqb_op  = {1'b0, ({1'b0, acc_q[63:16]} + 49'(eps_q)), 14'h0};

  adu_sqrt u_sqa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_go),
    .op_i   (sqa_op),
    .busy_o (sqa_busy),
    .root_o (sqa_root)
  );

  adu_sqrt u_sqb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_go),
    .op_i   (sqb_op),
    .busy_o (sqb_busy),
    .root_o (sqb_root)
  );

  // Divider for |g| * rootA / rootB.
  logic        div_go, div_busy, div_big;
  logic [32:0] div_quo;

  assign div_go = (state_q == adu_pkg::S_MQW2);

  adu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .num_i  (acc_q[63:0]),
    .den_i  (rb_q),
    .busy_o (div_busy),
    .big_o  (div_big),
    .quo_o  (div_quo)
  );

  // Quotient selection with saturation; a zero root in the denominator saturates
  // any nonzero gradient.
  logic [32:0] limit;
  logic [31:0] q_sel;
  logic        sat_sel;

  assign limit = neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;

  always_comb begin
    q_sel   = div_quo[31:0];
    sat_sel = 1'b0;
    if (rb_q == '0) begin
      q_sel   = (mag_q == '0) ? '0 : limit[31:0];
      sat_sel = (mag_q != '0);
    end else if (div_big || (div_quo > limit)) begin
      q_sel   = limit[31:0];
      sat_sel = 1'b1;
    end
  end

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_change_q;
  logic        out_sat_q;
  logic        out_load;

  assign out_load = (state_q == adu_pkg::S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_change_q <= neg_q ? (32'h0 - q_q) : q_q;
      out_sat_q    <= sat_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      adu_pkg::S_IDLE: if (accept) state_d = adu_pkg::S_LOAD;
      adu_pkg::S_LOAD: state_d = adu_pkg::S_SQ;
      adu_pkg::S_SQ:   state_d = adu_pkg::S_SQW1;
      adu_pkg::S_SQW1: state_d = adu_pkg::S_SQW2;
      adu_pkg::S_SQW2: state_d = adu_pkg::S_B0;
      adu_pkg::S_B0:   state_d = adu_pkg::S_B1;
      adu_pkg::S_B1:   state_d = adu_pkg::S_B2;
      adu_pkg::S_B2:   state_d = adu_pkg::S_B3;
      adu_pkg::S_B3:   state_d = adu_pkg::S_BW1;
      adu_pkg::S_BW1:  state_d = adu_pkg::S_BW2;
      adu_pkg::S_BW2:  state_d = pass_q ? adu_pkg::S_WB : adu_pkg::S_ROOT;
      adu_pkg::S_ROOT: if (!sqa_busy && !sqb_busy) state_d = adu_pkg::S_MQ;
      adu_pkg::S_MQ:   state_d = adu_pkg::S_MQW1;
      adu_pkg::S_MQW1: state_d = adu_pkg::S_MQW2;
      adu_pkg::S_MQW2: state_d = adu_pkg::S_DIV;
      adu_pkg::S_DIV:  if (!div_busy) state_d = adu_pkg::S_QSEL;
      adu_pkg::S_QSEL: state_d = adu_pkg::S_SQ;
      adu_pkg::S_WB:   state_d = adu_pkg::S_OUT;
      adu_pkg::S_OUT:  if (out_load) state_d = adu_pkg::S_IDLE;
      default:         state_d = adu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adu_pkg::S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pass_q <= 1'b0;
      end else if (state_q == adu_pkg::S_QSEL) begin
        pass_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= ram_raddr;
      in_range_q <= slot_ext < SLOTS_CMP_W'(adu_pkg::SLOTS);
      neg_q      <= g_in[31];
      mag_q      <= g_in[31] ? (32'h0 - g_in) : g_in;
    end
    if (state_q == adu_pkg::S_LOAD) begin
      if (in_range_q && vld_q[addr_q]) begin
        eg_old_q <= rd_data[MW-1:0];
        ed_old_q <= rd_data[2*MW-1:MW];
      end else begin
        eg_old_q <= '0;
        ed_old_q <= '0;
      end
    end
    if (state_q == adu_pkg::S_SQW2) begin
      x_q <= adu_pkg::clip48(acc_q);
    end
    if (state_q == adu_pkg::S_BW2) begin
      if (pass_q) begin
        ed_new_q <= acc_q[63:16];
      end else begin
        eg_new_q <= acc_q[63:16];
      end
    end
    if ((state_q == adu_pkg::S_ROOT) && !sqa_busy && !sqb_busy) begin
      rb_q <= sqb_root;
    end
    if (state_q == adu_pkg::S_QSEL) begin
      q_q   <= q_sel;
      sat_q <= sat_sel;
    end
  end

  assign s_axis_tready_o = (state_q == adu_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_change_q;
  assign m_axis_tuser_o  = out_sat_q;

  // A taken word leaves the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("block still ready after taking a word");

  // A saturated result always carries one of the two extreme values.
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o == 32'h8000_0000 || m_axis_tdata_o == 32'h7FFF_FFFF))
    else $error("saturated flag without an extreme change");

  // The root units and the divider are idle whenever a new word can be taken.
  a_roots_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!sqa_busy && !sqb_busy && !div_busy))
    else $error("arithmetic unit busy while idle");

endmodule
`default_nettype wire

/* rtl/adu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module adu_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/adu_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// Floor integer square root, one result bit per cycle.
module adu_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] op_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);

  logic [34:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [63:0] val_q, val_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [34:0] r2;
  logic [34:0] trial;

  always_comb begin
    r2     = {rem_q[32:0], val_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    rem_d  = rem_q;
    root_d = root_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      val_d  = op_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[61:0], 2'b00};
      if (r2 >= trial) begin
        rem_d  = r2 - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = r2;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

/* rtl/adu_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider for a 33-bit quotient; big_o flags a quotient of 2^33 or more.
module adu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             busy_o,
  output logic             big_o,
  output logic [32:0]      quo_o
);

  logic [31:0] rem_q, rem_d;
  logic [32:0] nb_q, nb_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        big_q, big_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] r2;

  always_comb begin
    r2     = {rem_q, nb_q[32]};
    rem_d  = rem_q;
    nb_d   = nb_q;
    quo_d  = quo_q;
    den_d  = den_q;
    big_d  = big_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      big_d  = {1'b0, num_i[63:33]} >= den_i;
      rem_d  = {1'b0, num_i[63:33]};
      nb_d   = num_i[32:0];
      quo_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      nb_d = {nb_q[31:0], 1'b0};
      if (r2 >= {1'b0, den_q}) begin
        rem_d = 32'(r2 - {1'b0, den_q});
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = r2[31:0];
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nb_q  <= nb_d;
    quo_q <= quo_d;
    den_q <= den_d;
    big_q <= big_d;
  end

  assign busy_o = busy_q;
  assign big_o  = big_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire
